### rtl/pps_pkg.sv
// Shared constants, codes and control structs of the ping probe sequencer.
// Used by the controller, the datapath, the divider and the top level.
package pps_pkg;

    localparam int MAX_PROBES = 8;
    localparam int IDX_W      = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam int CNT_W      = $clog2(MAX_PROBES + 1);
    localparam int SUM_W      = 16 + IDX_W;
    localparam int DIVC_W     = $clog2(SUM_W + 1);

    // Event modes.
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_OUTCOME = 3'd1;
    localparam logic [2:0] MODE_REPLY   = 3'd2;
    localparam logic [2:0] MODE_START   = 3'd3;
    localparam logic [2:0] MODE_STOP    = 3'd4;

    // Engine phases.
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_AWAIT    = 2'd1;
    localparam logic [1:0] PH_WAIT     = 2'd2;
    localparam logic [1:0] PH_REPORTED = 2'd3;

    // Probe table entry status.
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_SENT  = 2'd1;
    localparam logic [1:0] ST_OK    = 2'd2;
    localparam logic [1:0] ST_FAIL  = 2'd3;

    // Result kinds.
    localparam logic [1:0] RK_NONE   = 2'd0;
    localparam logic [1:0] RK_SEND   = 2'd1;
    localparam logic [1:0] RK_REPORT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TARGET   = 2'd0;
    localparam logic [1:0] CFG_COUNT    = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam logic [3:0]  PROBE_COUNT_RST = 4'd5;
    localparam logic [7:0]  INTERVAL_RST    = 8'd10;
    localparam logic [7:0]  TICK_MAX        = 8'hFF;
    localparam logic [15:0] RTT_NONE        = 16'hFFFF;
    localparam logic [15:0] FAIL_MARK       = 16'hFFFF;

    typedef struct packed {
        logic load;
        logic exec;
        logic search;
        logic scan;
        logic report;
        logic emit;
    } pps_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic need_search;
        logic hit;
        logic walk_last;
        logic scan_last;
    } pps_stat_t;

endpackage

### rtl/pps_div.sv
// Restoring divider, one quotient bit per cycle, for the mean RTT.
// Depends on pps_pkg for the operand widths.
module pps_div
    import pps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVC_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W:0]    partial;
    logic [CNT_W:0]    diff;

    assign partial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = partial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIVC_W'(SUM_W);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (partial >= {1'b0, divisor})
            begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIVC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/pps_ctrl.sv
// Sequencing state machine: decodes a request, walks the probe table for
// replies and reports, and starts the divider. Depends on pps_pkg.
module pps_ctrl
    import pps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  pps_stat_t stat,
    input  logic      div_done,
    output pps_cmd_t  cmd,
    output logic      div_start,
    output logic      busy,
    output logic      done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DIVGO  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_scan)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.need_search)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.hit || stat.walk_last)
                begin
                    cmd.emit   = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cmd.report = 1'b1;
                    cmd.emit   = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // A result appears only as the machine returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");

    // An accepted request is always decoded in the next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> state_reg == S_EXEC)
        else $error("accepted request not decoded");

endmodule

### rtl/pps_dp.sv
// Datapath: configuration, engine state, the probe table, report
// accumulators and the result registers. Depends on pps_pkg.
module pps_dp
    import pps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pps_cmd_t         cmd,
    output pps_stat_t        stat,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic [2:0]       mode,
    input  logic [15:0]      now_ms,
    input  logic [15:0]      seq_or_id,
    input  logic             send_failed,
    input  logic             reply_valid,
    output logic [SUM_W-1:0] div_dividend,
    output logic [CNT_W-1:0] div_divisor,
    input  logic [SUM_W-1:0] div_quotient,
    output logic [1:0]       result_kind,
    output logic [31:0]      send_address,
    output logic [3:0]       probes_counted,
    output logic [3:0]       probes_lost,
    output logic [15:0]      rtt_min,
    output logic [15:0]      rtt_max,
    output logic [15:0]      rtt_avg,
    output logic [1:0]       engine_phase
);

    // Configuration.
    logic [31:0] target_reg;
    logic [3:0]  count_reg;
    logic [7:0]  interval_reg;

    // Latched request.
    logic [2:0]  mode_reg;
    logic [15:0] now_reg;
    logic [15:0] sid_reg;
    logic        failed_reg;
    logic        valid_reg;

    // Engine state.
    logic [1:0]       phase_reg, phase_next;
    logic             enabled_reg, enabled_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [7:0]       tick_reg, tick_next;

    // Probe table; only the status has a reset, the rest is read only
    // where the status says the entry was written.
    logic [1:0]  status_reg [MAX_PROBES];
    logic [15:0] seq_reg    [MAX_PROBES];
    logic [15:0] time_reg   [MAX_PROBES];
    logic [15:0] rtt_reg    [MAX_PROBES];

    // Walk and report accumulators.
    logic [IDX_W-1:0] walk_reg;
    logic [CNT_W-1:0] counted_reg;
    logic [CNT_W-1:0] ok_reg;
    logic [15:0]      min_reg;
    logic [15:0]      max_reg;
    logic [SUM_W-1:0] sum_reg;

    // Result registers.
    logic [1:0]  rk_reg;
    logic [31:0] addr_reg;
    logic [3:0]  cnt_out_reg;
    logic [3:0]  lost_out_reg;
    logic [15:0] min_out_reg;
    logic [15:0] max_out_reg;
    logic [15:0] avg_out_reg;

    logic [CNT_W-1:0] run_len;
    logic [7:0]       tick_inc;
    logic             interval_end;
    logic             last_probe;
    logic             in_wait;
    logic             issue;
    logic             tick_report;
    logic [1:0]       walk_status;
    logic             hit;
    logic             table_empty;
    logic [1:0]       emit_kind;
    logic [CNT_W-1:0] lost;
    logic [15:0]      rtt_now;
    logic [15:0]      walk_rtt;

    always_comb
    begin
        if (count_reg == 4'd0)
        begin
            run_len = CNT_W'(1);
        end
        else if ({{(CNT_W+4){1'b0}}, count_reg} > (CNT_W+8)'(MAX_PROBES))
        begin
            run_len = CNT_W'(MAX_PROBES);
        end
        else
        begin
            run_len = CNT_W'(count_reg);
        end
    end

    assign tick_inc     = (tick_reg == TICK_MAX) ? TICK_MAX : tick_reg + 8'd1;
    assign interval_end = (tick_inc >= interval_reg);
    assign last_probe   = ({1'b0, pidx_reg} + 1'b1) >= (IDX_W+1)'(run_len);
    assign in_wait      = (phase_reg == PH_WAIT) && (mode_reg == MODE_TICK);
    assign tick_report  = in_wait && interval_end && last_probe;
    assign issue        = (mode_reg == MODE_START) ||
                          (in_wait && interval_end && !last_probe);

    assign walk_status = status_reg[walk_reg];
    assign hit         = (walk_status == ST_SENT) && (seq_reg[walk_reg] == sid_reg);
    assign rtt_now     = now_reg - time_reg[walk_reg];
    assign walk_rtt    = rtt_reg[walk_reg];
    assign lost        = counted_reg - ok_reg;

    always_comb
    begin
        table_empty = 1'b1;
        for (int i = 0; i < MAX_PROBES; i++)
        begin
            if (status_reg[i] != ST_EMPTY)
            begin
                table_empty = 1'b0;
            end
        end
    end

    assign stat.need_scan   = tick_report;
    assign stat.need_search = (mode_reg == MODE_REPLY) && valid_reg;
    assign stat.hit         = hit;
    assign stat.walk_last   = (walk_reg == IDX_W'(MAX_PROBES - 1));
    assign stat.scan_last   = ({1'b0, walk_reg} == (IDX_W+1)'(run_len - 1'b1));

    // Engine state updates for a decoded request and for the report.
    always_comb
    begin
        phase_next   = phase_reg;
        enabled_next = enabled_reg;
        pidx_next    = pidx_reg;
        tick_next    = tick_reg;
        if (cmd.exec)
        begin
            unique case (mode_reg)
                MODE_TICK:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        tick_next = tick_inc;
                        if (interval_end && !last_probe)
                        begin
                            pidx_next  = pidx_reg + 1'b1;
                            tick_next  = '0;
                            phase_next = PH_AWAIT;
                        end
                    end
                end
                MODE_OUTCOME:
                begin
                    if (phase_reg == PH_AWAIT)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                MODE_START:
                begin
                    enabled_next = 1'b1;
                    pidx_next    = '0;
                    tick_next    = '0;
                    phase_next   = PH_AWAIT;
                end
                MODE_STOP:
                begin
                    enabled_next = 1'b0;
                    if (phase_reg == PH_REPORTED)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.report)
        begin
            phase_next = enabled_reg ? PH_REPORTED : PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            count_reg    <= PROBE_COUNT_RST;
            interval_reg <= INTERVAL_RST;
            phase_reg    <= PH_IDLE;
            enabled_reg  <= 1'b0;
            pidx_reg     <= '0;
            tick_reg     <= '0;
            for (int i = 0; i < MAX_PROBES; i++)
            begin
                status_reg[i] <= ST_EMPTY;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TARGET:   target_reg   <= cfg_data;
                    CFG_COUNT:    count_reg    <= cfg_data[3:0];
                    CFG_INTERVAL: interval_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            phase_reg   <= phase_next;
            enabled_reg <= enabled_next;
            pidx_reg    <= pidx_next;
            tick_reg    <= tick_next;
            if ((cmd.exec && mode_reg == MODE_START) || cmd.report)
            begin
                for (int i = 0; i < MAX_PROBES; i++)
                begin
                    status_reg[i] <= ST_EMPTY;
                end
            end
            else if (cmd.exec && mode_reg == MODE_OUTCOME && phase_reg == PH_AWAIT)
            begin
                status_reg[pidx_reg] <= failed_reg ? ST_FAIL : ST_SENT;
            end
            else if (cmd.search && hit)
            begin
                status_reg[walk_reg] <= ST_OK;
            end
        end
    end

    // Table payload, request latch, walk and accumulators.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            now_reg    <= now_ms;
            sid_reg    <= seq_or_id;
            failed_reg <= send_failed;
            valid_reg  <= reply_valid;
        end
        if (cmd.exec && mode_reg == MODE_OUTCOME && phase_reg == PH_AWAIT)
        begin
            seq_reg[pidx_reg]  <= failed_reg ? FAIL_MARK : sid_reg;
            time_reg[pidx_reg] <= failed_reg ? FAIL_MARK : now_reg;
        end
        if (cmd.search && hit)
        begin
            rtt_reg[walk_reg] <= rtt_now;
        end
        if (cmd.exec)
        begin
            walk_reg    <= '0;
            counted_reg <= '0;
            ok_reg      <= '0;
            min_reg     <= RTT_NONE;
            max_reg     <= '0;
            sum_reg     <= '0;
        end
        else if (cmd.search)
        begin
            walk_reg <= walk_reg + 1'b1;
        end
        else if (cmd.scan)
        begin
            walk_reg <= walk_reg + 1'b1;
            if (walk_status == ST_SENT)
            begin
                counted_reg <= counted_reg + 1'b1;
            end
            else if (walk_status == ST_OK)
            begin
                counted_reg <= counted_reg + 1'b1;
                ok_reg      <= ok_reg + 1'b1;
                sum_reg     <= sum_reg + SUM_W'(walk_rtt);
                if (walk_rtt < min_reg)
                begin
                    min_reg <= walk_rtt;
                end
                if (walk_rtt > max_reg)
                begin
                    max_reg <= walk_rtt;
                end
            end
        end
    end

    always_comb
    begin
        if (cmd.report)
        begin
            emit_kind = RK_REPORT;
        end
        else if (cmd.exec && issue)
        begin
            emit_kind = RK_SEND;
        end
        else
        begin
            emit_kind = RK_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rk_reg       <= emit_kind;
            addr_reg     <= (emit_kind == RK_SEND) ? target_reg : 32'd0;
            cnt_out_reg  <= '0;
            lost_out_reg <= '0;
            min_out_reg  <= '0;
            max_out_reg  <= '0;
            avg_out_reg  <= '0;
            if (emit_kind == RK_REPORT)
            begin
                cnt_out_reg  <= 4'(counted_reg);
                lost_out_reg <= 4'(lost);
                min_out_reg  <= min_reg;
                max_out_reg  <= max_reg;
                avg_out_reg  <= (ok_reg == '0) ? 16'd0 : div_quotient[15:0];
            end
        end
    end

    assign div_dividend   = sum_reg;
    assign div_divisor    = ok_reg;
    assign result_kind    = rk_reg;
    assign send_address   = addr_reg;
    assign probes_counted = cnt_out_reg;
    assign probes_lost    = lost_out_reg;
    assign rtt_min        = min_out_reg;
    assign rtt_max        = max_out_reg;
    assign rtt_avg        = avg_out_reg;
    assign engine_phase   = phase_reg;

    // A report always leaves the table empty.
    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> table_empty)
        else $error("probe table not cleared by report");

    // A matched reply marks the entry it was found in as answered.
    a_hit_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.search && hit) |=> status_reg[$past(walk_reg)] == ST_OK)
        else $error("matched entry not marked answered");

    // The mean of answered probes lies between their extremes.
    a_avg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.report && ok_reg != '0) |=>
            (avg_out_reg >= min_out_reg && avg_out_reg <= max_out_reg))
        else $error("mean RTT outside min and max");

endmodule

### rtl/ping_probe_sequencer_top.sv
// Top level of the ping probe sequencer: controller, datapath and divider.
// Depends on pps_pkg, pps_ctrl, pps_dp and pps_div.
//
// A request is taken when start is high and busy is low. Exactly one result
// follows for every request. It is shown for a single cycle with done high,
// and the receiver has no way to hold it off. Ticks that do not end the run,
// send outcomes, start, stop, unused modes and invalid echo replies pass
// from the idle state through the decode state back to idle. A valid echo
// reply walks the probe table one entry per cycle until the first match or
// the last entry. A tick that ends the run walks the run's entries one per
// cycle. It then divides the RTT sum in a bit-serial divider, one quotient
// bit per cycle. A new request may be taken in the same cycle in which done
// is high. Configuration writes are taken at once.
module ping_probe_sequencer_top
    import pps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [2:0]  mode,
    input  logic [15:0] now_ms,
    input  logic [15:0] seq_or_id,
    input  logic        send_failed,
    input  logic        reply_valid,
    output logic [1:0]  result_kind,
    output logic [31:0] send_address,
    output logic [3:0]  probes_counted,
    output logic [3:0]  probes_lost,
    output logic [15:0] rtt_min,
    output logic [15:0] rtt_max,
    output logic [15:0] rtt_avg,
    output logic [1:0]  engine_phase
);

    pps_cmd_t         cmd;
    pps_stat_t        stat;
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_divisor;
    logic [SUM_W-1:0] div_quotient;

    pps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .stat      (stat),
        .div_done  (div_done),
        .cmd       (cmd),
        .div_start (div_start),
        .busy      (busy),
        .done      (done)
    );

    pps_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .now_ms         (now_ms),
        .seq_or_id      (seq_or_id),
        .send_failed    (send_failed),
        .reply_valid    (reply_valid),
        .div_dividend   (div_dividend),
        .div_divisor    (div_divisor),
        .div_quotient   (div_quotient),
        .result_kind    (result_kind),
        .send_address   (send_address),
        .probes_counted (probes_counted),
        .probes_lost    (probes_lost),
        .rtt_min        (rtt_min),
        .rtt_max        (rtt_max),
        .rtt_avg        (rtt_avg),
        .engine_phase   (engine_phase)
    );

    pps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

endmodule

### verif/tb_top.sv
// Self-checking testbench for ping_probe_sequencer_top: directed runs, then random probe traffic.
// Depends on pps_pkg and the RTL of the ping probe sequencer.
// Expected outputs come from an in-bench model of the probe engine and are checked per field.
module tb_top;
    import pps_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] now_ms;
        logic [15:0] seq_or_id;
        logic        send_failed;
        logic        reply_valid;
    } probe_event_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [3:0]  counted;
        logic [3:0]  lost;
        logic [15:0] rmin;
        logic [15:0] rmax;
        logic [15:0] ravg;
        logic [1:0]  phase;
    } engine_out_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic [2:0]  mode;
    logic [15:0] now_ms;
    logic [15:0] seq_or_id;
    logic        send_failed;
    logic        reply_valid;
    logic [1:0]  result_kind;
    logic [31:0] send_address;
    logic [3:0]  probes_counted;
    logic [3:0]  probes_lost;
    logic [15:0] rtt_min;
    logic [15:0] rtt_max;
    logic [15:0] rtt_avg;
    logic [1:0]  engine_phase;

    // Model copy of the configuration and of the engine state.
    logic [31:0] cfg_target;
    logic [3:0]  cfg_count;
    logic [7:0]  cfg_interval;
    logic [1:0]  m_phase;
    logic        m_enabled;
    logic [2:0]  m_probe_idx;
    logic [7:0]  m_ticks;
    logic [1:0]  m_status [MAX_PROBES];
    logic [15:0] m_seq [MAX_PROBES];
    logic [15:0] m_sent [MAX_PROBES];
    logic [15:0] m_rtt [MAX_PROBES];

    logic [15:0] ms_clock;
    logic [15:0] seq_next;
    engine_out_t engine_outputs_due[$];
    int          mismatches;
    int          stall_cycles;

    ping_probe_sequencer_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .now_ms         (now_ms),
        .seq_or_id      (seq_or_id),
        .send_failed    (send_failed),
        .reply_valid    (reply_valid),
        .result_kind    (result_kind),
        .send_address   (send_address),
        .probes_counted (probes_counted),
        .probes_lost    (probes_lost),
        .rtt_min        (rtt_min),
        .rtt_max        (rtt_max),
        .rtt_avg        (rtt_avg),
        .engine_phase   (engine_phase)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_probe_table();
        for (int i = 0; i < MAX_PROBES; i++)
        begin
            m_status[i] = ST_EMPTY;
            m_seq[i]    = '0;
            m_sent[i]   = '0;
            m_rtt[i]    = '0;
        end
    endfunction

    function automatic int unsigned run_length();
        int unsigned n;
        n = cfg_count;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_PROBES)
        begin
            n = MAX_PROBES;
        end
        return n;
    endfunction

    function automatic engine_out_t send_request();
        engine_out_t o;
        o = '0;
        m_ticks = '0;
        m_phase = PH_AWAIT;
        o.kind = RK_SEND;
        o.addr = cfg_target;
        return o;
    endfunction

    // Summarizes the run and empties the table; the engine stays reported only while enabled.
    function automatic engine_out_t run_report();
        engine_out_t o;
        int unsigned counted;
        int unsigned answered;
        int unsigned rtt_sum;
        logic [15:0] lo;
        logic [15:0] hi;
        o = '0;
        counted = 0;
        answered = 0;
        rtt_sum = 0;
        lo = RTT_NONE;
        hi = '0;
        for (int i = 0; i < run_length(); i++)
        begin
            if (m_status[i] == ST_SENT)
            begin
                counted++;
            end
            else if (m_status[i] == ST_OK)
            begin
                if (m_rtt[i] < lo)
                begin
                    lo = m_rtt[i];
                end
                if (m_rtt[i] > hi)
                begin
                    hi = m_rtt[i];
                end
                rtt_sum += m_rtt[i];
                answered++;
                counted++;
            end
        end
        o.kind    = RK_REPORT;
        o.counted = 4'(counted);
        o.lost    = 4'(counted - answered);
        o.rmin    = lo;
        o.rmax    = hi;
        o.ravg    = (answered != 0) ? 16'(rtt_sum / answered) : 16'd0;
        clear_probe_table();
        m_phase = m_enabled ? PH_REPORTED : PH_IDLE;
        return o;
    endfunction

    function automatic engine_out_t advance_engine(probe_event_t ev);
        engine_out_t o;
        o = '0;
        case (ev.mode)
            MODE_TICK:
            begin
                if (m_phase == PH_WAIT)
                begin
                    if (m_ticks < TICK_MAX)
                    begin
                        m_ticks++;
                    end
                    if (m_ticks >= cfg_interval)
                    begin
                        if (int'(m_probe_idx) + 1 >= run_length())
                        begin
                            o = run_report();
                        end
                        else
                        begin
                            m_probe_idx++;
                            o = send_request();
                        end
                    end
                end
            end
            MODE_OUTCOME:
            begin
                if (m_phase == PH_AWAIT)
                begin
                    if (ev.send_failed)
                    begin
                        m_status[m_probe_idx] = ST_FAIL;
                        m_seq[m_probe_idx]    = FAIL_MARK;
                        m_sent[m_probe_idx]   = FAIL_MARK;
                    end
                    else
                    begin
                        m_status[m_probe_idx] = ST_SENT;
                        m_seq[m_probe_idx]    = ev.seq_or_id;
                        m_sent[m_probe_idx]   = ev.now_ms;
                    end
                    m_phase = PH_WAIT;
                end
            end
            MODE_REPLY:
            begin
                if (ev.reply_valid)
                begin
                    for (int i = 0; i < MAX_PROBES; i++)
                    begin
                        if (m_status[i] == ST_SENT && m_seq[i] == ev.seq_or_id)
                        begin
                            m_rtt[i] = ev.now_ms - m_sent[i];
                            m_status[i] = ST_OK;
                            break;
                        end
                    end
                end
            end
            MODE_START:
            begin
                clear_probe_table();
                m_enabled = 1'b1;
                m_probe_idx = '0;
                o = send_request();
            end
            MODE_STOP:
            begin
                m_enabled = 1'b0;
                if (m_phase == PH_REPORTED)
                begin
                    m_phase = PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        o.phase = m_phase;
        return o;
    endfunction

    function automatic probe_event_t probe_ev(logic [2:0] md, logic [15:0] now,
                                              logic [15:0] sid, logic failed, logic valid);
        probe_event_t ev;
        ev.mode = md;
        ev.now_ms = now;
        ev.seq_or_id = sid;
        ev.send_failed = failed;
        ev.reply_valid = valid;
        return ev;
    endfunction

    // Picks the next event from the engine's current phase so that most runs complete,
    // with stray and malformed events mixed in.
    function automatic probe_event_t next_event();
        probe_event_t ev;
        int unsigned r;
        int unsigned pick;
        int unsigned open_slots[$];
        logic [15:0] rtt;
        ev.mode        = 3'($urandom_range(7));
        ev.now_ms      = 16'($urandom);
        ev.seq_or_id   = 16'($urandom);
        ev.send_failed = 1'($urandom);
        ev.reply_valid = 1'($urandom);
        ms_clock = ms_clock + 16'($urandom_range(0, 400));
        for (int i = 0; i < MAX_PROBES; i++)
        begin
            if (m_status[i] == ST_SENT)
            begin
                open_slots.push_back(i);
            end
        end
        r = $urandom_range(99);
        case (m_phase)
            PH_AWAIT:
            begin
                if (r < 85)
                begin
                    ev.mode = MODE_OUTCOME;
                    ev.now_ms = ms_clock;
                    ev.send_failed = ($urandom_range(7) == 0);
                    pick = $urandom_range(9);
                    // A repeated sequence number makes the reply pick the first waiting entry.
                    if (pick == 0)
                    begin
                        seq_next = 16'($urandom);
                    end
                    else if (pick > 1)
                    begin
                        seq_next = seq_next + 16'd1;
                    end
                    ev.seq_or_id = seq_next;
                end
            end
            PH_WAIT:
            begin
                if (r < 25 && open_slots.size() != 0)
                begin
                    pick = open_slots[$urandom_range(open_slots.size() - 1)];
                    rtt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
                    ev.mode = MODE_REPLY;
                    ev.seq_or_id = m_seq[pick];
                    ev.reply_valid = ($urandom_range(9) != 0);
                    ev.now_ms = m_sent[pick] + rtt;
                    ms_clock = ev.now_ms;
                end
                else if (r < 87)
                begin
                    ev.mode = MODE_TICK;
                end
            end
            default:
            begin
                if (r < 70)
                begin
                    ev.mode = MODE_START;
                end
                else if (r < 80)
                begin
                    ev.mode = MODE_STOP;
                end
                else if (r < 90)
                begin
                    ev.mode = MODE_REPLY;
                    ev.seq_or_id = seq_next;
                end
            end
        endcase
        return ev;
    endfunction

    task automatic send_item(probe_event_t ev, int unsigned idle_pct);
        int unsigned gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       = 1'b1;
        mode        = ev.mode;
        now_ms      = ev.now_ms;
        seq_or_id   = ev.seq_or_id;
        send_failed = ev.send_failed;
        reply_valid = ev.reply_valid;
        do
            @(posedge clk);
        while (busy);
        engine_outputs_due.push_back(advance_engine(ev));
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (engine_outputs_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_TARGET:   cfg_target = data;
            CFG_COUNT:    cfg_count = data[3:0];
            CFG_INTERVAL: cfg_interval = data[7:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_config(logic [31:0] target, logic [3:0] count, logic [7:0] interval);
        drain();
        write_reg(CFG_TARGET, target);
        write_reg(CFG_COUNT, 32'(count));
        write_reg(CFG_INTERVAL, 32'(interval));
    endtask

    task automatic random_traffic(int n_items, int unsigned idle_pct, bit with_pauses);
        for (int i = 0; i < n_items; i++)
        begin
            if (with_pauses && $urandom_range(31) == 0)
            begin
                drain();
            end
            send_item(next_event(), idle_pct);
        end
    endtask

    // Events that the idle engine ignores or only partly takes up.
    task automatic test_idle_events();
        send_item(probe_ev(MODE_STOP + 3'd1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1), 0);
        send_item(probe_ev(MODE_STOP + 3'd3, 16'h0000, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_TICK, 16'h0001, 16'h0002, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_OUTCOME, 16'h1234, 16'h5678, 1'b0, 1'b1), 0);
        send_item(probe_ev(MODE_REPLY, 16'h0000, 16'h0000, 1'b0, 1'b1), 0);
        send_item(probe_ev(MODE_STOP, 16'h0000, 16'h0000, 1'b0, 1'b0), 0);
    endtask

    // Three probes: an answered one whose RTT wraps, a failed one, an unanswered one.
    task automatic test_run_wrap_and_fail();
        set_config(32'hFFFF_FFFF, 4'd3, 8'd1);
        send_item(probe_ev(MODE_START, 16'h0000, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_OUTCOME, 16'hFFF0, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_OUTCOME, 16'h1111, 16'h2222, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_REPLY, 16'h0005, 16'h0000, 1'b0, 1'b1), 0);
        send_item(probe_ev(MODE_REPLY, 16'h0100, 16'h0000, 1'b0, 1'b1), 0);
        send_item(probe_ev(MODE_TICK, 16'h0200, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_TICK, 16'h0201, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_OUTCOME, 16'h4321, 16'h1234, 1'b1, 1'b0), 0);
        send_item(probe_ev(MODE_REPLY, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1), 0);
        send_item(probe_ev(MODE_TICK, 16'h0300, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_OUTCOME, 16'h0000, 16'hFFFF, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_REPLY, 16'h0010, 16'hFFFF, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_TICK, 16'h0400, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_REPLY, 16'h0500, 16'hFFFF, 1'b0, 1'b1), 0);
        send_item(probe_ev(MODE_STOP, 16'h0000, 16'h0000, 1'b0, 1'b0), 0);
    endtask

    // Restart mid-run, a zero probe count and interval, and a stop that waits for the report.
    task automatic test_restart_clamp_stop();
        set_config(32'h0000_0000, 4'd0, 8'd0);
        send_item(probe_ev(MODE_START, 16'h0000, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_OUTCOME, 16'd100, 16'd7, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_START, 16'd120, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_OUTCOME, 16'd200, 16'd7, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_REPLY, 16'd150, 16'd7, 1'b0, 1'b1), 0);
        send_item(probe_ev(MODE_STOP, 16'h0000, 16'h0000, 1'b0, 1'b0), 0);
        send_item(probe_ev(MODE_TICK, 16'd300, 16'h0000, 1'b0, 1'b0), 0);
    endtask

    task automatic test_back_to_back();
        set_config(32'($urandom), 4'd8, 8'd1);
        random_traffic(300, 0, 1'b0);
    endtask

    task automatic test_sparse_sender();
        set_config(32'($urandom), 4'($urandom_range(1, 8)), 8'd2);
        random_traffic(250, 78, 1'b1);
    endtask

    task automatic test_long_interval();
        set_config(32'($urandom), 4'd1, 8'd255);
        random_traffic(350, 18, 1'b0);
    endtask

    task automatic test_clamped_count();
        set_config(32'($urandom), 4'd15, 8'd3);
        random_traffic(250, 18, 1'b1);
    endtask

    task automatic test_mixed_settings();
        for (int i = 0; i < 4; i++)
        begin
            set_config(32'($urandom), 4'($urandom_range(1, 8)), 8'($urandom_range(1, 6)));
            random_traffic(50, 0, 1'b0);
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_outputs
        engine_out_t want;
        if (rst_n && done)
        begin
            if (engine_outputs_due.size() == 0)
            begin
                $error("result seen with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = engine_outputs_due.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(result_kind));
                check_field("send_address", want.addr, send_address);
                check_field("probes_counted", 32'(want.counted), 32'(probes_counted));
                check_field("probes_lost", 32'(want.lost), 32'(probes_lost));
                check_field("rtt_min", 32'(want.rmin), 32'(rtt_min));
                check_field("rtt_max", 32'(want.rmax), 32'(rtt_max));
                check_field("rtt_avg", 32'(want.ravg), 32'(rtt_avg));
                check_field("engine_phase", 32'(want.phase), 32'(engine_phase));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ping_probe_sequencer_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_TARGET;
        cfg_data     = '0;
        mode         = MODE_TICK;
        now_ms       = '0;
        seq_or_id    = '0;
        send_failed  = 1'b0;
        reply_valid  = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        ms_clock     = '0;
        seq_next     = '0;
        cfg_target   = '0;
        cfg_count    = PROBE_COUNT_RST;
        cfg_interval = INTERVAL_RST;
        m_phase      = PH_IDLE;
        m_enabled    = 1'b0;
        m_probe_idx  = '0;
        m_ticks      = '0;
        clear_probe_table();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_events();
        test_run_wrap_and_fail();
        test_restart_clamp_stop();
        test_back_to_back();
        test_sparse_sender();
        test_long_interval();
        test_clamped_count();
        test_mixed_settings();

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && engine_outputs_due.size() == 0)
        begin
            $display("ping_probe_sequencer_top regression: pass");
        end
        else
        begin
            $display("ping_probe_sequencer_top regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/pps_pkg.sv
rtl/pps_div.sv
rtl/pps_ctrl.sv
rtl/pps_dp.sv
rtl/ping_probe_sequencer_top.sv
verif/tb_top.sv
